@@ hdl/c128_pkg.sv @@
package c128_pkg;

   localparam logic [6:0] SymStartB   = 7'd104;
   localparam logic [6:0] SymStop     = 7'd106;
   localparam logic [6:0] CheckMod    = 7'd103;
   localparam logic [6:0] AsciiOffset = 7'd32;
   localparam logic [6:0] LastWeight  = 7'd102;
   localparam logic [6:0] SumReset    = 7'd1;
   localparam logic [6:0] WeightReset = 7'd1;
   localparam int         PatCount    = 107;
   localparam logic [2:0] LastRunIdx  = 3'd5;
   localparam logic [2:0] FinalWidth  = 3'd2;

   // floor(x / 103) for x below 2^14 is this estimate or one more
   localparam logic [7:0] RecipMul    = 8'd159;
   localparam int         RecipShift  = 14;

   localparam int         QueueDepth  = 2;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_EST,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_START,
      B_CHAR,
      B_CHECK,
      B_STOP,
      B_FINAL
   } back_state_type;

   typedef struct packed {
      logic       start;
      logic [6:0] symbol;
      logic       last;
      logic [6:0] check;
   } entry_type;

   // six run widths per symbol, one nibble each, bar first in the top nibble
   localparam logic [23:0] PatternTable [PatCount] = '{
      24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222,
      24'h122213, 24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212,
      24'h112232, 24'h122132, 24'h122231, 24'h113222, 24'h123122, 24'h123221,
      24'h223211, 24'h221132, 24'h221231, 24'h213212, 24'h223112, 24'h312131,
      24'h311222, 24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
      24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123, 24'h131321,
      24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
      24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121,
      24'h313121, 24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131,
      24'h311123, 24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
      24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422, 24'h121124,
      24'h121421, 24'h141122, 24'h141221, 24'h112214, 24'h112412, 24'h122114,
      24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114, 24'h413111,
      24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
      24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
      24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113,
      24'h114311, 24'h411113, 24'h411311, 24'h113141, 24'h114131, 24'h311141,
      24'h411131, 24'h211412, 24'h211214, 24'h211232, 24'h233111
   };

   function automatic logic [23:0] c128_pattern(input logic [6:0] sym);
      logic [23:0] pat;
      if (sym < 7'(PatCount)) begin
         pat = PatternTable[sym];
      end else begin
         pat = PatternTable[0];
      end
      return pat;
   endfunction

endpackage

@@ hdl/c128_queue.sv @@
module c128_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  c128_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output c128_pkg::entry_type pop_entry
);
   import c128_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   entry_type        slot_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = (count_ff < CntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QueueDepth))
      else $error("queue count beyond depth");

endmodule

@@ hdl/c128_front.sv @@
module c128_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [6:0]          req_char,
   input  logic                req_last,
   output logic                push_valid,
   input  logic                push_ready,
   output c128_pkg::entry_type push_entry
);
   import c128_pkg::*;

   front_state_type state_ff, state_in;
   logic [6:0]      sym_ff, sym_in;
   logic            last_ff;
   logic            start_ff;
   logic            started_ff, started_in;
   logic [6:0]      weight_ff, weight_in;
   logic [6:0]      sum_ff, sum_in;
   logic [13:0]     prod_ff;
   logic [13:0]     x_ff, x_in;
   logic [6:0]      q_ff, q_in;
   logic [21:0]     est;
   logic [13:0]     rem_wide;
   logic [7:0]      rem_raw;
   logic [6:0]      check;
   logic            accept;
   logic            push_fire;

   // output decode
   always_comb begin
      push_valid = (state_ff == F_PUSH);
      push_fire  = push_valid && push_ready;
      req_ready  = (state_ff == F_IDLE) || push_fire;
      accept     = req_valid && req_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (accept) state_in = F_MUL;
         F_MUL:   state_in = F_EST;
         F_EST:   state_in = F_PUSH;
         F_PUSH:  begin
            if (push_fire) begin
               state_in = accept ? F_MUL : F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // checksum datapath: multiply, estimate quotient, correct remainder
   always_comb begin
      sym_in     = (req_char < AsciiOffset) ? '0 : req_char - AsciiOffset;
      started_in = accept ? !req_last : started_ff;
      x_in       = 14'(sum_ff) + prod_ff;
      est        = 22'(x_in) * 22'(RecipMul);
      q_in       = est[RecipShift +: 7];
      rem_wide   = x_ff - 14'(q_ff) * 14'(CheckMod);
      rem_raw    = rem_wide[7:0];
      check      = (rem_raw >= 8'(CheckMod)) ? 7'(rem_raw - 8'(CheckMod)) : rem_raw[6:0];
      weight_in  = weight_ff;
      if (state_ff == F_MUL) begin
         if (last_ff) begin
            weight_in = WeightReset;
         end else begin
            weight_in = (weight_ff == LastWeight) ? '0 : weight_ff + 1'b1;
         end
      end
      sum_in = sum_ff;
      if (push_fire) begin
         sum_in = last_ff ? SumReset : check;
      end
   end

   assign push_entry = '{start: start_ff, symbol: sym_ff, last: last_ff, check: check};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         started_ff <= 1'b0;
         weight_ff  <= WeightReset;
         sum_ff     <= SumReset;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
         weight_ff  <= weight_in;
         sum_ff     <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sym_ff   <= sym_in;
         last_ff  <= req_last;
         start_ff <= !started_ff;
      end
      if (state_ff == F_MUL) begin
         prod_ff <= 14'(sym_ff) * 14'(weight_ff);
      end
      if (state_ff == F_EST) begin
         x_ff <= x_in;
         q_ff <= q_in;
      end
   end

   a_sum_reduced: assert property (@(posedge clock) disable iff (reset)
      sum_ff < CheckMod)
      else $error("checksum not reduced");

   a_weight_reduced: assert property (@(posedge clock) disable iff (reset)
      weight_ff < CheckMod)
      else $error("position weight not reduced");

endmodule

@@ hdl/c128_back.sv @@
module c128_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  c128_pkg::entry_type pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_width,
   output logic                rsp_space,
   output logic                rsp_last
);
   import c128_pkg::*;

   back_state_type state_ff, state_in;
   logic [2:0]     run_ff, run_in;
   entry_type      cur_ff;
   logic           rsp_valid_ff;
   logic [2:0]     rsp_width_ff;
   logic           rsp_space_ff;
   logic           rsp_last_ff;
   logic           adv;
   logic           emit;
   logic           run_end;
   logic           item_end;
   logic           load;
   logic [6:0]     sym_sel;
   logic [23:0]    pat;
   logic [4:0]     nib_pos;
   logic [2:0]     run_width;
   logic           run_space;
   logic           run_last;
   back_state_type first_state;

   // output decode
   always_comb begin
      adv      = !rsp_valid_ff || rsp_ready;
      emit     = (state_ff != B_IDLE) && adv;
      run_end  = (state_ff == B_FINAL) || (run_ff == LastRunIdx);
      item_end = emit && ((state_ff == B_FINAL) ||
                 (state_ff == B_CHAR && run_ff == LastRunIdx && !cur_ff.last));
      load     = pop_valid && ((state_ff == B_IDLE) || item_end);
      pop_ready = load;
      first_state = pop_entry.start ? B_START : B_CHAR;

      case (state_ff)
         B_START: sym_sel = SymStartB;
         B_CHAR:  sym_sel = cur_ff.symbol;
         B_CHECK: sym_sel = cur_ff.check;
         B_STOP:  sym_sel = SymStop;
         default: sym_sel = '0;
      endcase
      pat     = c128_pattern(sym_sel);
      nib_pos = 5'(4 * LastRunIdx) - {run_ff, 2'b00};
      if (state_ff == B_FINAL) begin
         run_width = FinalWidth;
         run_space = 1'b0;
         run_last  = 1'b1;
      end else begin
         run_width = pat[nib_pos +: 3];
         run_space = run_ff[0];
         run_last  = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      run_in   = run_ff;
      if (emit) begin
         run_in = run_end ? '0 : run_ff + 1'b1;
         if (run_end) begin
            case (state_ff)
               B_START: state_in = B_CHAR;
               B_CHAR:  state_in = cur_ff.last ? B_CHECK : B_IDLE;
               B_CHECK: state_in = B_STOP;
               B_STOP:  state_in = B_FINAL;
               B_FINAL: state_in = B_IDLE;
               default: state_in = B_IDLE;
            endcase
         end
      end
      if (load) begin
         state_in = first_state;
         run_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         if (adv) begin
            rsp_valid_ff <= (state_ff != B_IDLE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= pop_entry;
      end
      if (emit) begin
         rsp_width_ff <= run_width;
         rsp_space_ff <= run_space;
         rsp_last_ff  <= run_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_width = rsp_width_ff;
   assign rsp_space = rsp_space_ff;
   assign rsp_last  = rsp_last_ff;

   a_width_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_width_ff >= 3'd1 && rsp_width_ff <= 3'd4))
      else $error("run width out of range");

   a_final_bar: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_width_ff == FinalWidth && !rsp_space_ff))
      else $error("closing run is not a two-module bar");

   a_load_between_items: assert property (@(posedge clock) disable iff (reset)
      load |-> (state_ff == B_IDLE || state_ff == B_CHAR || state_ff == B_FINAL))
      else $error("new request taken in the middle of a symbol");

endmodule

@@ hdl/code128b_bar_width_encoder_unit.sv @@
// Code 128 set B encoder: turns a stream of ASCII characters into bar and
// space run widths, one run per output transfer.
// Request channel: req_tdata[6:0] carries the character, req_tlast marks the
// final character of a message. Codes below 32 encode as a space.
// Response channel: rsp_tdata[2:0] is the run width in modules (1 to 4),
// rsp_tuser is 0 for a dark bar and 1 for a light space, rsp_tlast flags the
// closing 2-module bar of the symbol.
// Each character gives 6 runs; the first of a message is preceded by the
// 6-run start pattern; the last is followed by checksum (6), stop (6) and
// the closing bar (1). Runs leave at one per cycle while rsp_tready is high
// and the queue holds work. The front works through three steps (multiply,
// quotient estimate, remainder fix for the modulo-103 checksum) and can take
// the next request while it pushes the last; a two-entry queue parts it from
// the run sequencer, which sets the sustained rate. An accepted request passes
// the product, estimate and queue registers; its runs leave from the output one.
// Reset clears the checksum to 1, the position weight to 1 and drops any
// queued work. When rsp_tready is low the current run holds in the output
// register; the queue fills and then req_tready drops.
module code128b_bar_width_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [6:0] char_code, [7] zero
   input  logic       req_tlast,   // is_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] run_width, [7:3] zero
   output logic       rsp_tuser,   // is_space
   output logic       rsp_tlast    // last_run
);
   import c128_pkg::*;

   entry_type  push_entry;
   entry_type  pop_entry;
   logic       push_valid;
   logic       push_ready;
   logic       pop_valid;
   logic       pop_ready;
   logic [2:0] rsp_width;

   c128_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_char   (req_tdata[6:0]),
      .req_last   (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   c128_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   c128_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_width  (rsp_width),
      .rsp_space  (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, rsp_width};

endmodule
